// ===== src/fscr_pkg.sv =====
package fscr_pkg;

  // Framing bytes, the speed command letter and the decimal digit range
  localparam logic [7:0] StxByte  = 8'h02;
  localparam logic [7:0] EtxByte  = 8'h03;
  localparam logic [7:0] SpeedCmd = 8'h53;
  localparam logic [7:0] DigitLo  = 8'h30;
  localparam logic [7:0] DigitHi  = 8'h39;

  // Reset values of the configuration and the drive outputs
  localparam logic [7:0] UnitIdReset = 8'h41;
  localparam logic [7:0] CompareOff  = 8'hFF;

  // Checksum rules
  localparam logic [12:0] ChecksumFloor = 13'd32;
  localparam logic [7:0]  ChecksumBias  = 8'd32;
  localparam logic [13:0] SumLimit      = 14'd8191;
  localparam logic [12:0] SumFoldBase   = 13'h1000;

  // Digit accumulation saturates here
  localparam logic [11:0] ValueSat = 12'd255;

  // One result item
  typedef struct packed {
    logic       frame_end;
    logic       check_ok;
    logic [7:0] pwm_compare;
    logic       direction_relay;
    logic       led_on;
  } fscr_result_t;

endpackage

// ===== src/fscr_core.sv =====
module fscr_core #(
  parameter int MAX_MESSAGE_BYTES = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           unit_id_i,
  output fscr_pkg::fscr_result_t result_o
);
  import fscr_pkg::*;

  localparam logic [5:0] MaxCount = 6'(MAX_MESSAGE_BYTES);

  logic        capturing_q, capturing_d;
  logic [5:0]  count_q, count_d;
  logic        overflow_q, overflow_d;
  logic [12:0] sum_q, sum_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  val_prev_q, val_prev_d;
  logic [7:0]  val_q, val_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  third_q, third_d;
  logic [7:0]  compare_q, compare_d;
  logic        relay_q, relay_d;
  logic        led_q, led_d;

  logic [13:0] sum_add;
  logic [12:0] sum_next;
  logic        is_digit;
  logic [11:0] val_mac;
  logic [7:0]  val_next;
  logic [7:0]  check_calc;
  logic        close_ok;
  logic [7:0]  d0, d2;
  logic        addressed;
  logic        frame_end;

  // Fold the running sum so its low byte and the floor test stay exact
  assign sum_add  = {1'b0, sum_q} + {6'd0, last_q};
  assign sum_next = (sum_add > SumLimit) ? (SumFoldBase | {5'd0, sum_add[7:0]})
                                         : sum_add[12:0];

  // Accumulate a decimal digit, saturated
  assign is_digit = (rx_byte_i >= DigitLo) && (rx_byte_i <= DigitHi);
  assign val_mac  = {1'b0, val_q, 3'd0} + {3'd0, val_q, 1'b0}
                  + {4'd0, rx_byte_i - DigitLo};
  assign val_next = !is_digit ? val_q :
                    (val_mac > ValueSat) ? ValueSat[7:0] : val_mac[7:0];

  // Checksum and address test on the stored message
  assign check_calc = (sum_q < ChecksumFloor) ? (sum_q[7:0] + ChecksumBias) : sum_q[7:0];
  assign close_ok   = (count_q != 6'd0) && !overflow_q && (check_calc == last_q);
  assign d0         = (count_q >= 6'd2) ? first_q : 8'd0;
  assign d2         = (count_q >= 6'd4) ? third_q : 8'd0;
  assign addressed  = (d0 == unit_id_i) && (d2 == SpeedCmd);

  assign frame_end = en_i && capturing_q && (rx_byte_i == EtxByte);

  // Next state for one request
  always_comb begin
    capturing_d = capturing_q;
    count_d     = count_q;
    overflow_d  = overflow_q;
    sum_d       = sum_q;
    last_d      = last_q;
    val_prev_d  = val_prev_q;
    val_d       = val_q;
    first_d     = first_q;
    third_d     = third_q;
    compare_d   = compare_q;
    relay_d     = relay_q;
    led_d       = led_q;

    if (en_i) begin
      if (rx_byte_i == StxByte || frame_end) begin
        // Open or close a message: drop the captured bytes
        capturing_d = (rx_byte_i == StxByte);
        count_d     = '0;
        overflow_d  = 1'b0;
        sum_d       = '0;
        last_d      = '0;
        val_prev_d  = '0;
        val_d       = '0;
        first_d     = '0;
        third_d     = '0;
        if (frame_end) begin
          if (!close_ok) begin
            compare_d = CompareOff;
            led_d     = 1'b0;
          end else begin
            led_d = 1'b1;
            if (addressed) begin
              if (val_prev_q == 8'd0) begin
                compare_d = CompareOff;
              end else if (val_prev_q[7]) begin
                relay_d   = 1'b0;
                compare_d = ~{val_prev_q[6:0], 1'b0};
              end else begin
                relay_d   = 1'b1;
                compare_d = {val_prev_q[6:0], 1'b0};
              end
            end
          end
        end
      end else if (capturing_q && rx_byte_i != 8'd0) begin
        // Append a message byte, or mark the message overlong
        if (count_q >= MaxCount) begin
          overflow_d = 1'b1;
        end else begin
          if (count_q != 6'd0) begin
            sum_d = sum_next;
          end
          val_prev_d = val_q;
          val_d      = val_next;
          if (count_q == 6'd0) begin
            first_d = rx_byte_i;
          end
          if (count_q == 6'd2) begin
            third_d = rx_byte_i;
          end
          last_d  = rx_byte_i;
          count_d = count_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      sum_q       <= '0;
      last_q      <= '0;
      val_prev_q  <= '0;
      val_q       <= '0;
      first_q     <= '0;
      third_q     <= '0;
      compare_q   <= CompareOff;
      relay_q     <= 1'b0;
      led_q       <= 1'b0;
    end else begin
      capturing_q <= capturing_d;
      count_q     <= count_d;
      overflow_q  <= overflow_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      val_prev_q  <= val_prev_d;
      val_q       <= val_d;
      first_q     <= first_d;
      third_q     <= third_d;
      compare_q   <= compare_d;
      relay_q     <= relay_d;
      led_q       <= led_d;
    end
  end

  // Result for the byte being processed
  assign result_o.frame_end       = frame_end;
  assign result_o.check_ok        = frame_end && close_ok;
  assign result_o.pwm_compare     = compare_d;
  assign result_o.direction_relay = relay_d;
  assign result_o.led_on          = led_d;

endmodule

// ===== src/framed_speed_command_receiver.sv =====
// An accepted byte reaches its result through the input register and then the result register.
// Throughput: one byte per cycle while the output is not stalled; every byte gives exactly one result.
// The message state updates as a byte moves from the input register to the result register.
// Reset (rst_ni low, asynchronous): no message open, unit ID 0x41,
// compare 255 (motor off), relay and LED off, both pipeline registers empty.
module framed_speed_command_receiver #(
  parameter int MAX_MESSAGE_BYTES = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_end_o,
  output logic       check_ok_o,
  output logic [7:0] pwm_compare_o,
  output logic       direction_relay_o,
  output logic       led_on_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import fscr_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  fscr_result_t out_q;
  fscr_result_t result;
  logic [7:0]   unit_id_q;
  logic         advance;
  logic         accept;

  // Move the held request on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold the configured unit ID
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_id_q <= UnitIdReset;
    end else if (cfg_we_i) begin
      unit_id_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  fscr_core #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .rx_byte_i(in_byte_q),
    .unit_id_i(unit_id_q),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_end_o       = out_q.frame_end;
  assign check_ok_o        = out_q.check_ok;
  assign pwm_compare_o     = out_q.pwm_compare;
  assign direction_relay_o = out_q.direction_relay;
  assign led_on_o          = out_q.led_on;

endmodule

// ===== src/fscr_checker.sv =====
module fscr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       frame_end_o,
  input logic       check_ok_o,
  input logic [7:0] pwm_compare_o,
  input logic       direction_relay_o,
  input logic       led_on_o
);
  import fscr_pkg::*;

  // A passed checksum only comes with a closed message
  a_ok_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_ok_o |-> frame_end_o)
    else $error("check_ok without frame_end");

  // A passed checksum lights the LED
  a_ok_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_ok_o |-> led_on_o)
    else $error("LED off after good checksum");

  // A failed message stops the motor and darkens the LED
  a_bad_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && !check_ok_o |-> pwm_compare_o == CompareOff && !led_on_o)
    else $error("motor not stopped after bad message");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_end_o)
      && $stable(check_ok_o) && $stable(pwm_compare_o)
      && $stable(direction_relay_o) && $stable(led_on_o))
    else $error("stalled result changed");

endmodule

bind framed_speed_command_receiver fscr_checker u_fscr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .frame_end_o      (frame_end_o),
  .check_ok_o       (check_ok_o),
  .pwm_compare_o    (pwm_compare_o),
  .direction_relay_o(direction_relay_o),
  .led_on_o         (led_on_o)
);
